// ===== src/afc_pkg.sv =====
package afc_pkg;

  localparam int DATA_W         = 32;
  localparam int PROD_W         = 2 * DATA_W;
  localparam int PART_W         = PROD_W + 1;
  localparam int ACC_W          = PROD_W + 2;
  localparam int FRAC_W         = 16;
  localparam int SLOT_W         = 3;
  localparam int CFG_W          = 4;
  localparam int VIS_W          = 2;
  localparam int MAX_PLANES_DEF = 8;

  localparam logic [CFG_W-1:0] NUM_PLANES_RST = 4'd6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } opcode_t;

  typedef enum logic [VIS_W-1:0] {
    VIS_VISIBLE = 2'd0,
    VIS_CLIPPED = 2'd1,
    VIS_CULLED  = 2'd2
  } vis_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [DATA_W-1:0] nz;
    logic signed [DATA_W-1:0] off;
  } plane_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_x;
    logic signed [DATA_W-1:0] min_y;
    logic signed [DATA_W-1:0] min_z;
    logic signed [DATA_W-1:0] max_x;
    logic signed [DATA_W-1:0] max_y;
    logic signed [DATA_W-1:0] max_z;
  } box_t;

  // Outcome of one plane test, returned to the sequencer.
  typedef struct packed {
    logic vld;
    logic near_pos;
    logic far_nneg;
  } eval_t;

endpackage

// ===== src/aabb_frustum_cull.sv =====
// Box culling against a table of outward-facing planes.
// Input channel (in_valid/in_ready) carries two kinds of item. A load item
// (in_opcode 0) writes one plane into the slot in_plane_slot and gives no
// result. A test item (in_opcode 1) carries a box's min and max corners
// and gives exactly one out_visibility result: 0 visible,
// 1 clipped, 2 culled.
// A test walks the plane memory one entry per cycle through a three-stage
// multiply and sum pipeline, over the planes in use (at most 8 by default);
// the memory read port issues one plane per cycle.
// The result sits in an output register; the block accepts the next item
// while it waits. If out_ready stays low, a second test finishes its walk and
// then holds in_ready low until the earlier result is taken.
// The plane count is written through cfg_valid/cfg_ready and must only change
// while the block is idle. Reset sets the count to 6 and empties the output;
// the plane table is not cleared and must be loaded before use.
module aabb_frustum_cull #(
  parameter int MAX_PLANES = afc_pkg::MAX_PLANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [afc_pkg::SLOT_W-1:0]        in_plane_slot,
  input  logic signed [afc_pkg::DATA_W-1:0] in_normal_x,
  input  logic signed [afc_pkg::DATA_W-1:0] in_normal_y,
  input  logic signed [afc_pkg::DATA_W-1:0] in_normal_z,
  input  logic signed [afc_pkg::DATA_W-1:0] in_plane_offset,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_min_x,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_min_y,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_min_z,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_max_x,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_max_y,
  input  logic signed [afc_pkg::DATA_W-1:0] in_box_max_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [afc_pkg::VIS_W-1:0]         out_visibility,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [afc_pkg::CFG_W-1:0]         cfg_num_planes
);

  localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CW = $clog2(MAX_PLANES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              rcv_r, rcv_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       cull_r, cull_nxt;
  logic                       clip_r, clip_nxt;
  logic                       out_valid_r, out_valid_nxt;
  afc_pkg::vis_t              out_vis_r, out_vis_nxt;
  logic [afc_pkg::CFG_W-1:0]  num_planes_r;
  logic                       rd_vld_r;
  afc_pkg::box_t              box_r;

  logic                       in_acc, test_acc, load_acc;
  logic [CW-1:0]              count_lim;
  afc_pkg::plane_t            wr_plane, rd_plane;
  afc_pkg::eval_t             ev;
  logic                       issue;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign test_acc  = in_acc && (in_opcode == afc_pkg::OP_TEST);
  // Slots past the table are dropped.
  assign load_acc  = in_acc && (in_opcode == afc_pkg::OP_LOAD)
                     && (int'(in_plane_slot) < MAX_PLANES);
  assign issue     = (state_r == S_ISSUE);

  always_comb begin
    if (int'(num_planes_r) > MAX_PLANES) begin
      count_lim = CW'(MAX_PLANES);
    end else begin
      count_lim = CW'(num_planes_r);
    end
  end

  assign wr_plane.nx  = in_normal_x;
  assign wr_plane.ny  = in_normal_y;
  assign wr_plane.nz  = in_normal_z;
  assign wr_plane.off = in_plane_offset;

  afc_plane_mem #(
    .DEPTH (MAX_PLANES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (AW'(in_plane_slot)),
    .wr_data (wr_plane),
    .rd_en   (issue),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_plane)
  );

  afc_plane_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r),
    .plane  (rd_plane),
    .box    (box_r),
    .result (ev)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rcv_nxt       = rcv_r;
    count_nxt     = count_r;
    cull_nxt      = cull_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vis_nxt   = out_vis_r;

    if (ev.vld) begin
      rcv_nxt  = rcv_r + 1'b1;
      cull_nxt = cull_r || ev.near_pos;
      clip_nxt = clip_r || ev.far_nneg;
    end

    case (state_r)
      S_IDLE: begin
        if (test_acc) begin
          count_nxt = count_lim;
          cnt_nxt   = '0;
          rcv_nxt   = '0;
          cull_nxt  = 1'b0;
          clip_nxt  = 1'b0;
          state_nxt = (count_lim == '0) ? S_DRAIN : S_ISSUE;
        end
      end
      S_ISSUE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == count_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (rcv_r == count_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cull_r) begin
            out_vis_nxt = afc_pkg::VIS_CULLED;
          end else if (clip_r) begin
            out_vis_nxt = afc_pkg::VIS_CLIPPED;
          end else begin
            out_vis_nxt = afc_pkg::VIS_VISIBLE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      rcv_r        <= '0;
      count_r      <= '0;
      cull_r       <= 1'b0;
      clip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_vis_r    <= afc_pkg::VIS_VISIBLE;
      num_planes_r <= afc_pkg::NUM_PLANES_RST;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rcv_r       <= rcv_nxt;
      count_r     <= count_nxt;
      cull_r      <= cull_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
      out_vis_r   <= out_vis_nxt;
      rd_vld_r    <= issue;
      if (cfg_valid && cfg_ready) begin
        num_planes_r <= cfg_num_planes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_acc) begin
      box_r.min_x <= in_box_min_x;
      box_r.min_y <= in_box_min_y;
      box_r.min_z <= in_box_min_z;
      box_r.max_x <= in_box_max_x;
      box_r.max_y <= in_box_max_y;
      box_r.max_z <= in_box_max_z;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_visibility = out_vis_r;

endmodule

// ===== src/afc_plane_mem.sv =====
module afc_plane_mem #(
  parameter int DEPTH = afc_pkg::MAX_PLANES_DEF,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  afc_pkg::plane_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output afc_pkg::plane_t  rd_data
);

  afc_pkg::plane_t plane_mem_r [DEPTH];
  afc_pkg::plane_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      plane_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= plane_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/afc_plane_eval.sv =====
module afc_plane_eval (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  afc_pkg::plane_t  plane,
  input  afc_pkg::box_t    box,
  output afc_pkg::eval_t   result
);

  localparam int DW = afc_pkg::DATA_W;
  localparam int PW = afc_pkg::PROD_W;
  localparam int SW = afc_pkg::PART_W;
  localparam int AW = afc_pkg::ACC_W;

  logic signed [DW-1:0] near_x, near_y, near_z, far_x, far_y, far_z;

  logic signed [PW-1:0] pnx_r, pny_r, pnz_r, pfx_r, pfy_r, pfz_r;
  logic signed [SW-1:0] off_r;
  logic                 s1_vld_r;

  logic signed [SW-1:0] na_r, nb_r, fa_r, fb_r;
  logic                 s2_vld_r;

  logic signed [AW-1:0] near_sum, far_sum;
  logic                 res_vld_r, near_pos_r, far_nneg_r;

  // A non-negative normal component puts the near corner on the minimum side.
  always_comb begin
    near_x = plane.nx[DW-1] ? box.max_x : box.min_x;
    far_x  = plane.nx[DW-1] ? box.min_x : box.max_x;
    near_y = plane.ny[DW-1] ? box.max_y : box.min_y;
    far_y  = plane.ny[DW-1] ? box.min_y : box.max_y;
    near_z = plane.nz[DW-1] ? box.max_z : box.min_z;
    far_z  = plane.nz[DW-1] ? box.min_z : box.max_z;
  end

  always_ff @(posedge clk) begin
    pnx_r <= plane.nx * near_x;
    pny_r <= plane.ny * near_y;
    pnz_r <= plane.nz * near_z;
    pfx_r <= plane.nx * far_x;
    pfy_r <= plane.ny * far_y;
    pfz_r <= plane.nz * far_z;
    off_r <= SW'(signed'({plane.off, {afc_pkg::FRAC_W{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    na_r <= SW'(pnx_r) + SW'(pny_r);
    nb_r <= SW'(pnz_r) + off_r;
    fa_r <= SW'(pfx_r) + SW'(pfy_r);
    fb_r <= SW'(pfz_r) + off_r;
  end

  assign near_sum = AW'(na_r) + AW'(nb_r);
  assign far_sum  = AW'(fa_r) + AW'(fb_r);

  always_ff @(posedge clk) begin
    near_pos_r <= !near_sum[AW-1] && (|near_sum);
    far_nneg_r <= !far_sum[AW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      res_vld_r <= s2_vld_r;
    end
  end

  assign result.vld      = res_vld_r;
  assign result.near_pos = near_pos_r;
  assign result.far_nneg = far_nneg_r;

endmodule

// ===== dv/tb_aabb_frustum_cull.sv =====
module tb_aabb_frustum_cull;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  localparam int TABLE_DEPTH   = MAX_PLANES_DEF;
  localparam int ONE           = 1 << FRAC_W;
  localparam int MAXV          = 32'sh7fff_ffff;
  localparam int MINV          = 32'sh8000_0000;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 300;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    plane_t            plane;
    box_t              box;
  } cull_item_t;

  // Keeps a copy of the plane table and the plane count, and the queue of
  // visibility codes still owed by the block.
  class cull_checker;
    plane_t           planes[TABLE_DEPTH];
    logic [CFG_W-1:0] plane_count;
    vis_t             expected_vis[$];
    int               failures;
    int               mismatches;

    function new();
      plane_count = NUM_PLANES_RST;
      failures    = 0;
      mismatches  = 0;
      foreach (planes[k]) planes[k] = '0;
    endfunction

    function void set_plane_count(logic [CFG_W-1:0] n);
      plane_count = n;
    endfunction

    // Sign of N.p + D for stored plane k, worked out exactly in Q32.32.
    function int distance_sign(int k, logic signed [DATA_W-1:0] px, py, pz);
      logic signed [PROD_W+2:0] nx, ny, nz, ox, cx, cy, cz, sum;
      nx  = $signed(planes[k].nx);
      ny  = $signed(planes[k].ny);
      nz  = $signed(planes[k].nz);
      ox  = $signed(planes[k].off);
      cx  = px;
      cy  = py;
      cz  = pz;
      sum = nx * cx + ny * cy + nz * cz + (ox <<< FRAC_W);
      if (sum < 0) return -1;
      return (sum == 0) ? 0 : 1;
    endfunction

    function vis_t classify_box(box_t b);
      int                       count;
      bit                       clipped;
      logic signed [DATA_W-1:0] ax, ay, az, fx, fy, fz;
      count   = (plane_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(plane_count);
      clipped = 1'b0;
      for (int k = 0; k < count; k++) begin
        // A negative normal component takes the max corner as the near one.
        ax = planes[k].nx[DATA_W-1] ? b.max_x : b.min_x;
        fx = planes[k].nx[DATA_W-1] ? b.min_x : b.max_x;
        ay = planes[k].ny[DATA_W-1] ? b.max_y : b.min_y;
        fy = planes[k].ny[DATA_W-1] ? b.min_y : b.max_y;
        az = planes[k].nz[DATA_W-1] ? b.max_z : b.min_z;
        fz = planes[k].nz[DATA_W-1] ? b.min_z : b.max_z;
        if (distance_sign(k, ax, ay, az) > 0) return VIS_CULLED;
        if (distance_sign(k, fx, fy, fz) >= 0) clipped = 1'b1;
      end
      return clipped ? VIS_CLIPPED : VIS_VISIBLE;
    endfunction

    function void note_item(cull_item_t it);
      if (it.op == OP_LOAD) begin
        planes[it.slot] = it.plane;
      end else begin
        expected_vis.push_back(classify_box(it.box));
      end
    endfunction

    function void check_visibility(logic [VIS_W-1:0] got);
      vis_t want;
      if (expected_vis.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected visibility result %0d with nothing outstanding", got);
      end else begin
        want = expected_vis.pop_front();
        if (got !== want) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("visibility mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_opcode = 1'b0;
  logic [SLOT_W-1:0]         in_plane_slot = '0;
  logic signed [DATA_W-1:0]  in_normal_x = '0;
  logic signed [DATA_W-1:0]  in_normal_y = '0;
  logic signed [DATA_W-1:0]  in_normal_z = '0;
  logic signed [DATA_W-1:0]  in_plane_offset = '0;
  logic signed [DATA_W-1:0]  in_box_min_x = '0;
  logic signed [DATA_W-1:0]  in_box_min_y = '0;
  logic signed [DATA_W-1:0]  in_box_min_z = '0;
  logic signed [DATA_W-1:0]  in_box_max_x = '0;
  logic signed [DATA_W-1:0]  in_box_max_y = '0;
  logic signed [DATA_W-1:0]  in_box_max_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [VIS_W-1:0]          out_visibility;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_num_planes = '0;

  cull_checker sb = new();
  bit          hold_req = 1'b0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  aabb_frustum_cull dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_plane_slot   (in_plane_slot),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_plane_offset (in_plane_offset),
    .in_box_min_x    (in_box_min_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_min_z    (in_box_min_z),
    .in_box_max_x    (in_box_max_x),
    .in_box_max_y    (in_box_max_y),
    .in_box_max_z    (in_box_max_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_visibility  (out_visibility),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_num_planes  (cfg_num_planes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_visibility(out_visibility);
  end

  // Result side: segments of steady, random, sparse or periodic readiness,
  // with one long hold-off on request.
  initial begin : result_pacing
    int mode, seg, tick, hold;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        end
        tick++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_extreme();
    return $urandom_range(0, 1) ? MAXV : MINV;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_normal();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return rand_extreme();
      2:       return int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
      default: return (int'($urandom_range(0, 2)) - 1) * ONE;
    endcase
  endfunction

  function automatic plane_t rand_plane();
    plane_t p;
    p.nx = rand_normal();
    p.ny = rand_normal();
    p.nz = rand_normal();
    case ($urandom_range(0, 7))
      0:       p.off = $urandom;
      1:       p.off = rand_extreme();
      default: p.off = (int'($urandom_range(0, 40)) - 30) * ONE;
    endcase
    return p;
  endfunction

  function automatic box_t rand_box();
    box_t b;
    int   lo[3], hi[3];
    int   c, h, mode;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      c = $urandom_range(0, 1) ? (int'($urandom_range(0, 48)) - 24) * ONE
                               : int'($urandom_range(0, 48 * ONE)) - 24 * ONE;
      h = $urandom_range(0, 1) ? int'($urandom_range(0, 8)) * ONE
                               : int'($urandom_range(0, 8 * ONE));
      if (mode == 0) begin
        // Arbitrary corners over the whole range, extremes included.
        case ($urandom_range(0, 3))
          0:       lo[a] = $urandom;
          1:       lo[a] = rand_extreme();
          default: lo[a] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
        hi[a] = $urandom_range(0, 1) ? int'($urandom) : rand_extreme();
      end else if (mode == 1) begin
        lo[a] = c + h;
        hi[a] = c - h;
      end else begin
        lo[a] = c - h;
        hi[a] = c + h;
      end
    end
    b.min_x = lo[0];
    b.min_y = lo[1];
    b.min_z = lo[2];
    b.max_x = hi[0];
    b.max_y = hi[1];
    b.max_z = hi[2];
    return b;
  endfunction

  // Fields an item does not use still carry random data.
  function automatic cull_item_t rand_item();
    cull_item_t it;
    it.plane = {$urandom, $urandom, $urandom, $urandom};
    it.box   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it.slot  = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    if ($urandom_range(0, 9) == 0) begin
      it.op = $urandom_range(0, 1) ? OP_TEST : OP_LOAD;
    end else if ($urandom_range(0, 4) == 0) begin
      it.op    = OP_LOAD;
      it.plane = rand_plane();
    end else begin
      it.op  = OP_TEST;
      it.box = rand_box();
    end
    return it;
  endfunction

  function automatic cull_item_t mk_load(int slot, int nx, int ny, int nz, int off);
    cull_item_t it;
    it           = rand_item();
    it.op        = OP_LOAD;
    it.slot      = SLOT_W'(slot);
    it.plane.nx  = nx;
    it.plane.ny  = ny;
    it.plane.nz  = nz;
    it.plane.off = off;
    return it;
  endfunction

  function automatic cull_item_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
    cull_item_t it;
    it           = rand_item();
    it.op        = OP_TEST;
    it.box.min_x = x0;
    it.box.min_y = y0;
    it.box.min_z = z0;
    it.box.max_x = x1;
    it.box.max_y = y1;
    it.box.max_z = z1;
    return it;
  endfunction

  // Offers one item, waits for it to be taken, then keeps to the burst pattern.
  task automatic send_item(input cull_item_t it);
    in_valid        <= 1'b1;
    in_opcode       <= it.op;
    in_plane_slot   <= it.slot;
    in_normal_x     <= it.plane.nx;
    in_normal_y     <= it.plane.ny;
    in_normal_z     <= it.plane.nz;
    in_plane_offset <= it.plane.off;
    in_box_min_x    <= it.box.min_x;
    in_box_min_y    <= it.box.min_y;
    in_box_min_z    <= it.box.min_z;
    in_box_max_x    <= it.box.max_x;
    in_box_max_y    <= it.box.max_y;
    in_box_max_z    <= it.box.max_z;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Loads give no result, so the block is given time to finish after the
  // last visibility result before the plane count may change.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_vis.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_plane_count(input logic [CFG_W-1:0] n);
    cfg_valid      <= 1'b1;
    cfg_num_planes <= n;
    do @(posedge clk); while (!cfg_ready);
    sb.set_plane_count(n);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int n, s;
    logic [CFG_W-1:0] count;
    plane_t fresh;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A cube of half-size ten, then a plane with extreme terms and one with a zero normal.
    send_item(mk_load(0,  ONE, 0, 0, -10 * ONE));
    send_item(mk_load(1, -ONE, 0, 0, -10 * ONE));
    send_item(mk_load(2, 0,  ONE, 0, -10 * ONE));
    send_item(mk_load(3, 0, -ONE, 0, -10 * ONE));
    send_item(mk_load(4, 0, 0,  ONE, -10 * ONE));
    send_item(mk_load(5, 0, 0, -ONE, -10 * ONE));
    send_item(mk_load(6, MAXV, MINV, -1, MINV));
    send_item(mk_load(7, 0, 0, 0, -1));

    send_item(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_item(mk_box(-20 * ONE, -20 * ONE, -20 * ONE, 20 * ONE, 20 * ONE, 20 * ONE));
    send_item(mk_box(11 * ONE, -ONE, -ONE, 12 * ONE, ONE, ONE));
    // Far corner exactly on the plane, then near corner exactly on it.
    send_item(mk_box(-5 * ONE, -ONE, -ONE, 10 * ONE, ONE, ONE));
    send_item(mk_box(10 * ONE, -ONE, -ONE, 12 * ONE, ONE, ONE));
    send_item(mk_box(5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE, -5 * ONE));
    send_item(mk_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));
    send_item(mk_box(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_item(mk_box(MINV, MINV, MINV, MINV, MINV, MINV));

    drain();
    write_plane_count(4'd0);
    send_item(mk_box(11 * ONE, 11 * ONE, 11 * ONE, 12 * ONE, 12 * ONE, 12 * ONE));
    send_item(mk_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));

    drain();
    write_plane_count(4'd15);
    send_item(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_item(mk_box(-20 * ONE, -20 * ONE, -20 * ONE, 20 * ONE, 20 * ONE, 20 * ONE));

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase)
        0:       count = 4'd8;
        1:       count = 4'd1;
        2:       count = 4'd15;
        3:       count = 4'd0;
        4:       count = 4'd7;
        default: count = CFG_W'($urandom_range(0, 15));
      endcase
      write_plane_count(count);
      if (phase == 2) hold_req = 1'b1;
      // Each phase starts by reloading part of the table with fresh planes.
      for (s = 0; s < TABLE_DEPTH; s++) begin
        if ($urandom_range(0, 1)) begin
          fresh = rand_plane();
          send_item(mk_load(s, fresh.nx, fresh.ny, fresh.nz, fresh.off));
        end
      end
      for (n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
    end

    drain();
    if (sb.failures == 0 && sb.expected_vis.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
